/* rtl/sfcs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sfcs_pkg;

  // actions for the spi byte engine
  typedef enum logic [2:0] {
    ActSelect   = 3'd0,
    ActRelease  = 3'd1,
    ActShiftOut = 3'd2,
    ActShiftIn  = 3'd3,
    ActWait     = 3'd4
  } action_e;

  // configuration register indexes
  localparam logic [2:0] RegReadOp       = 3'd0;
  localparam logic [2:0] RegProgramOp    = 3'd1;
  localparam logic [2:0] RegSectorEraseOp = 3'd2;
  localparam logic [2:0] RegBlockEraseOp = 3'd3;
  localparam logic [2:0] RegWriteEnableOp = 3'd4;

  // step slots of one request, carried out lowest first
  localparam int unsigned NumSteps = 14;
  localparam int unsigned StepW    = 4;

  localparam logic [StepW-1:0] StepCloseRel  = 4'd0;
  localparam logic [StepW-1:0] StepCloseWait = 4'd1;
  localparam logic [StepW-1:0] StepWeSel     = 4'd2;
  localparam logic [StepW-1:0] StepWeOp      = 4'd3;
  localparam logic [StepW-1:0] StepWeRel     = 4'd4;
  localparam logic [StepW-1:0] StepCmdSel    = 4'd5;
  localparam logic [StepW-1:0] StepCmdOp     = 4'd6;
  localparam logic [StepW-1:0] StepAddrHi    = 4'd7;
  localparam logic [StepW-1:0] StepAddrMid   = 4'd8;
  localparam logic [StepW-1:0] StepAddrLo    = 4'd9;
  localparam logic [StepW-1:0] StepData      = 4'd10;
  localparam logic [StepW-1:0] StepShiftIn   = 4'd11;
  localparam logic [StepW-1:0] StepTailRel   = 4'd12;
  localparam logic [StepW-1:0] StepTailWait  = 4'd13;

  typedef logic [NumSteps-1:0] step_mask_t;

  // step groups
  localparam step_mask_t WeMask   = 14'b00_0000_0001_1100;
  localparam step_mask_t CmdMask  = 14'b00_0011_1110_0000;
  localparam step_mask_t TailMask = 14'b11_0000_0000_0000;

  // reset values of the opcode registers
  localparam logic [7:0] ReadOpReset        = 8'h03;
  localparam logic [7:0] ProgramOpReset     = 8'h02;
  localparam logic [7:0] SectorEraseOpReset = 8'h20;
  localparam logic [7:0] BlockEraseOpReset  = 8'hD8;
  localparam logic [7:0] WriteEnableOpReset = 8'h06;

  typedef struct packed {
    logic [7:0] read_op;
    logic [7:0] program_op;
    logic [7:0] sector_erase_op;
    logic [7:0] block_erase_op;
    logic [7:0] write_enable_op;
  } cfg_t;

  // one classified request: which steps to run and their operands
  typedef struct packed {
    step_mask_t  steps;
    logic [7:0]  opcode;
    logic [23:0] address;
    logic [7:0]  data;
  } desc_t;

endpackage

`default_nettype wire

/* rtl/sfcs_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module sfcs_front
  import sfcs_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire logic        full_i,
  input  wire logic [2:0]  kind_i,
  input  wire logic [23:0] address_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire cfg_t        cfg_i,
  output logic             q_push_o,
  output desc_t            q_desc_o
);

  localparam logic [23:0] PageMask = 24'(PAGE_BYTES - 1);

  typedef enum logic [2:0] {
    KindBeginRead    = 3'd0,
    KindBeginProgram = 3'd1,
    KindProgramByte  = 3'd2,
    KindReadNext     = 3'd3,
    KindSectorErase  = 3'd4,
    KindBlockErase   = 3'd5,
    KindEnd          = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ModeIdle     = 2'd0,
    ModeRead     = 2'd1,
    ModeProgOpen = 2'd2,
    ModeProgGap  = 2'd3
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [23:0] addr_q, addr_d;
  logic        accept;
  step_mask_t  close_steps;
  logic [23:0] addr_inc;
  desc_t       desc;

  assign accept   = push_i & ~full_i;
  assign addr_inc = addr_q + 24'd1;

  // steps that close whatever transaction is open
  always_comb begin
    close_steps = '0;
    close_steps[StepCloseRel]  = (mode_q == ModeRead) || (mode_q == ModeProgOpen);
    close_steps[StepCloseWait] = (mode_q == ModeProgOpen);
  end

  // classify the request against the current mode
  always_comb begin
    desc         = '0;
    desc.opcode  = cfg_i.read_op;
    desc.address = address_i;
    desc.data    = data_byte_i;
    mode_d       = mode_q;
    addr_d       = addr_q;
    case (kind_i)
      KindBeginRead: begin
        desc.steps = close_steps | CmdMask;
        addr_d     = address_i;
        mode_d     = ModeRead;
      end
      KindBeginProgram: begin
        desc.steps  = close_steps | WeMask | CmdMask;
        desc.opcode = cfg_i.program_op;
        addr_d      = address_i;
        mode_d      = ModeProgOpen;
      end
      KindProgramByte: begin
        if (mode_q == ModeProgGap || mode_q == ModeProgOpen) begin
          desc.opcode  = cfg_i.program_op;
          desc.address = addr_q;
          if (mode_q == ModeProgGap) begin
            desc.steps = WeMask | CmdMask;
          end
          desc.steps[StepData] = 1'b1;
          addr_d = addr_inc;
          if ((addr_inc & PageMask) == 24'd0) begin
            desc.steps = desc.steps | TailMask;
            mode_d     = ModeProgGap;
          end else begin
            mode_d = ModeProgOpen;
          end
        end
      end
      KindReadNext: begin
        if (mode_q == ModeRead) begin
          desc.steps[StepShiftIn] = 1'b1;
          addr_d = addr_inc;
        end
      end
      KindSectorErase: begin
        desc.steps  = close_steps | WeMask | CmdMask | TailMask;
        desc.opcode = cfg_i.sector_erase_op;
        addr_d      = address_i;
        mode_d      = ModeIdle;
      end
      KindBlockErase: begin
        desc.steps  = close_steps | WeMask | CmdMask | TailMask;
        desc.opcode = cfg_i.block_erase_op;
        addr_d      = address_i;
        mode_d      = ModeIdle;
      end
      KindEnd: begin
        desc.steps = close_steps;
        mode_d     = ModeIdle;
      end
      default: begin
      end
    endcase
  end

  // requests with no action never enter the queue
  assign q_push_o = accept && (desc.steps != '0);
  assign q_desc_o = desc;

  // transaction state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      addr_q <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      addr_q <= addr_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/sfcs_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module sfcs_queue
  import sfcs_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  wr_en_i,
  input  wire desc_t wr_desc_i,
  input  wire logic  rd_en_i,
  output desc_t      rd_desc_o,
  output logic       full_o,
  output logic       empty_o
);

  desc_t       mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;

  assign full_o    = (count_q == 2'd2);
  assign empty_o   = (count_q == 2'd0);
  assign rd_desc_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_desc_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (rd_en_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (wr_en_i && !rd_en_i) begin
        count_q <= count_q + 2'd1;
      end else if (rd_en_i && !wr_en_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/sfcs_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module sfcs_back
  import sfcs_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  q_empty_i,
  input  wire desc_t q_desc_i,
  output logic       q_pop_o,
  input  wire logic  pop_i,
  output logic       empty_o,
  output logic [2:0] action_o,
  output logic [7:0] tx_byte_o,
  output logic       last_o
);

  desc_t            cur_q;
  logic             out_valid_q;
  action_e          action_q;
  logic [7:0]       tx_byte_q;
  logic             last_q;

  logic             out_load;
  logic             advance;
  logic             finishing;
  step_mask_t       low_bit;
  step_mask_t       rest;
  logic [StepW-1:0] idx;
  action_e          act;
  logic [7:0]       tx;

  // pick the lowest pending step
  assign low_bit = cur_q.steps & (~cur_q.steps + step_mask_t'(1));
  assign rest    = cur_q.steps & ~low_bit;

  always_comb begin
    idx = '0;
    for (int i = 0; i < NumSteps; i++) begin
      if (low_bit[i]) begin
        idx = StepW'(i);
      end
    end
  end

  // step to action
  always_comb begin
    act = ActRelease;
    tx  = 8'd0;
    case (idx) inside
      StepCloseRel, StepWeRel, StepTailRel: begin
        act = ActRelease;
      end
      StepCloseWait, StepTailWait: begin
        act = ActWait;
      end
      StepWeSel, StepCmdSel: begin
        act = ActSelect;
      end
      StepWeOp: begin
        act = ActShiftOut;
        tx  = cfg_i.write_enable_op;
      end
      StepCmdOp: begin
        act = ActShiftOut;
        tx  = cur_q.opcode;
      end
      StepAddrHi: begin
        act = ActShiftOut;
        tx  = cur_q.address[23:16];
      end
      StepAddrMid: begin
        act = ActShiftOut;
        tx  = cur_q.address[15:8];
      end
      StepAddrLo: begin
        act = ActShiftOut;
        tx  = cur_q.address[7:0];
      end
      StepData: begin
        act = ActShiftOut;
        tx  = cur_q.data;
      end
      StepShiftIn: begin
        act = ActShiftIn;
      end
      default: begin
        act = ActRelease;
      end
    endcase
  end

  // issue one action per cycle while the output slot is free
  assign out_load  = ~out_valid_q | pop_i;
  assign advance   = (cur_q.steps != '0) & out_load;
  assign finishing = (cur_q.steps == '0) | (advance & (rest == '0));
  assign q_pop_o   = finishing & ~q_empty_i;

  // current request and its operands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        cur_q <= q_desc_i;
      end else if (advance) begin
        cur_q.steps <= rest;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      action_q  <= act;
      tx_byte_q <= tx;
      last_q    <= (rest == '0);
    end
  end

  assign empty_o   = ~out_valid_q;
  assign action_o  = action_q;
  assign tx_byte_o = tx_byte_q;
  assign last_o    = last_q;

endmodule

`default_nettype wire

/* rtl/spi_flash_command_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none

// SPI NOR flash command sequencer. Each request (begin read, begin program,
// program byte, read next, sector erase, block erase, end) becomes a short
// list of byte-engine actions: select, release, shift out, shift in, wait.
// Requests enter through a push/full queue port; a front stage classifies
// them against the open transaction and places a step list in a two-entry
// queue, and a back stage issues one action per clock, while its one-entry
// result register is free or being popped, into that register, read through
// empty/pop. A request passes the queue, the current-request register and
// the result register before its first action is on the result ports; a
// request has 1 to 12 actions, and single-action requests follow back to
// back. Requests that cause no action (a stray program byte or read next,
// end with no transaction open, kind 7) are taken and produce nothing.
// Opcodes live in five 8-bit registers written through the cfg port, which
// is always ready; they must only be written while no request is in flight.
// PAGE_BYTES must be a power of two; programmed data is cut at every
// multiple of it.

module spi_flash_command_sequencer
  import sfcs_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request queue side
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  kind_i,
  input  wire logic [23:0] address_i,
  input  wire logic [7:0]  data_byte_i,
  // result queue side
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       action_o,
  output logic [7:0]       tx_byte_o,
  output logic             last_o,
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  cfg_t  cfg_q;
  logic  q_push, q_pop, q_full, q_empty;
  desc_t q_wr_desc, q_rd_desc;

  assign cfg_ready_o = 1'b1;

  // opcode registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.read_op         <= ReadOpReset;
      cfg_q.program_op      <= ProgramOpReset;
      cfg_q.sector_erase_op <= SectorEraseOpReset;
      cfg_q.block_erase_op  <= BlockEraseOpReset;
      cfg_q.write_enable_op <= WriteEnableOpReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegReadOp:        cfg_q.read_op         <= cfg_data_i;
        RegProgramOp:     cfg_q.program_op      <= cfg_data_i;
        RegSectorEraseOp: cfg_q.sector_erase_op <= cfg_data_i;
        RegBlockEraseOp:  cfg_q.block_erase_op  <= cfg_data_i;
        RegWriteEnableOp: cfg_q.write_enable_op <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign full = q_full;

  // request classification
  sfcs_front #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_i     (q_full),
    .kind_i     (kind_i),
    .address_i  (address_i),
    .data_byte_i(data_byte_i),
    .cfg_i      (cfg_q),
    .q_push_o   (q_push),
    .q_desc_o   (q_wr_desc)
  );

  // decoupling queue
  sfcs_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (q_push),
    .wr_desc_i(q_wr_desc),
    .rd_en_i  (q_pop),
    .rd_desc_o(q_rd_desc),
    .full_o   (q_full),
    .empty_o  (q_empty)
  );

  // action issue
  sfcs_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .q_empty_i(q_empty),
    .q_desc_i (q_rd_desc),
    .q_pop_o  (q_pop),
    .pop_i    (pop),
    .empty_o  (empty),
    .action_o (action_o),
    .tx_byte_o(tx_byte_o),
    .last_o   (last_o)
  );

endmodule

`default_nettype wire

/* rtl/sfcs_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module sfcs_checker
  import sfcs_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [2:0] action_o,
  input wire logic [7:0] tx_byte_o,
  input wire logic       last_o
);

  // a waiting result holds until transferred
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(action_o) && $stable(tx_byte_o)))
    else $error("result changed before transfer");

  // only defined actions leave the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (action_o == ActSelect || action_o == ActRelease ||
                action_o == ActShiftOut || action_o == ActShiftIn ||
                action_o == ActWait))
    else $error("undefined action");

  // only shift out carries a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && action_o != ActShiftOut) |-> (tx_byte_o == 8'd0))
    else $error("byte on a non shift-out action");

  // a select always has more to follow within the same request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && action_o == ActSelect) |-> !last_o)
    else $error("request ended on a select");

endmodule

bind spi_flash_command_sequencer sfcs_checker u_checker (.*);

`default_nettype wire
